// ===== hdl/dps_pkg.sv =====
// package for the deband pixel select block
// holds pixel width, mode and register codes, config struct and the shared
// arithmetic helpers; no dependencies
package dps_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam int THR_W      = 16;
    localparam int MID_W      = 17;
    localparam int MODE_W     = 3;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 17;
    localparam int CMP_W      = MID_W;

    localparam logic [MODE_W-1:0] PICK_MODE_RST = 3'd2;

    typedef logic [PIXEL_BITS-1:0] t_pix;
    typedef logic [PIXEL_BITS:0]   t_pix_sum;

    typedef enum logic [MODE_W-1:0] {
        MODE_VERT = 3'd1,
        MODE_DIAG = 3'd2,
        MODE_HORZ = 3'd3,
        MODE_BOTH = 3'd4,
        MODE_FULL = 3'd5
    } t_mode;

    typedef enum logic [IDX_W-1:0] {
        REG_PICK_MODE = 3'd0,
        REG_AVG_CMP   = 3'd1,
        REG_THR_AVG   = 3'd2,
        REG_THR_MAX   = 3'd3,
        REG_THR_MID   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [MODE_W-1:0] pick_mode;
        logic              avg_cmp;
        logic [THR_W-1:0]  thr_avg;
        logic [THR_W-1:0]  thr_max;
        logic [MID_W-1:0]  thr_mid;
    } t_cfg;

    typedef struct packed {
        t_pix pix;
        logic kept;
    } t_pair;

    function automatic t_pix absdiff(input t_pix a, input t_pix b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic t_pix_sum absdiff_sum(input t_pix_sum a, input t_pix_sum b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic t_pix mean2(input t_pix a, input t_pix b);
        logic [PIXEL_BITS:0] s;
        s = (PIXEL_BITS+1)'(a) + (PIXEL_BITS+1)'(b) + (PIXEL_BITS+1)'(1);
        return s[PIXEL_BITS:1];
    endfunction

    function automatic t_pix mean4(input t_pix a, input t_pix b, input t_pix c,
                                   input t_pix d);
        logic [PIXEL_BITS+1:0] s;
        s = (PIXEL_BITS+2)'(a) + (PIXEL_BITS+2)'(b) + (PIXEL_BITS+2)'(c)
          + (PIXEL_BITS+2)'(d) + (PIXEL_BITS+2)'(2);
        return s[PIXEL_BITS+1:2];
    endfunction

    function automatic logic reaches(input t_pix d, input logic [THR_W-1:0] thr);
        return CMP_W'(d) >= CMP_W'(thr);
    endfunction

    function automatic t_pair pair_select(input t_pix ctr, input t_pix r1, input t_pix r2,
                                          input logic blur, input logic [THR_W-1:0] thr);
        t_pair res;
        t_pix  avg;
        avg = mean2(r1, r2);
        if (blur) begin
            res.kept = reaches(absdiff(avg, ctr), thr);
        end else begin
            res.kept = reaches(absdiff(ctr, r1), thr) || reaches(absdiff(ctr, r2), thr);
        end
        res.pix = res.kept ? ctr : avg;
        return res;
    endfunction

endpackage

// ===== hdl/deband_pixel_select.sv =====
// top level of the deband pixel select block
// depends on dps_pkg, dps_cfg_regs and dps_decide
//
// Takes one pixel neighborhood (center plus four refs) per clock and returns
// one result per clock while the output is not stalled, through an input register,
// the threshold decision logic and a result register; a transaction moves
// from the input register into the result register, which drives the output.
// The input side keeps accepting while a finished result waits, stalling
// only when both stages are full and the output is stalled. Registers are
// written through the config channel, which is always ready, and must be
// written only while no transaction is in flight; an index past the last
// register is ignored.
module deband_pixel_select (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dps_pkg::FIELD_W-1:0]    i_center_pixel,
    input  logic [dps_pkg::FIELD_W-1:0]    i_ref_up,
    input  logic [dps_pkg::FIELD_W-1:0]    i_ref_down,
    input  logic [dps_pkg::FIELD_W-1:0]    i_ref_right,
    input  logic [dps_pkg::FIELD_W-1:0]    i_ref_left,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dps_pkg::FIELD_W-1:0]    o_filtered_pixel,
    output logic                          o_kept_original,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dps_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [dps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dps_pkg::*;

    t_cfg cfg;
    logic r_s1_valid;
    t_pix r_ctr;
    t_pix r_up;
    t_pix r_dn;
    t_pix r_rt;
    t_pix r_lf;
    logic r_out_valid;
    t_pix r_pix;
    logic r_kept;
    t_pix n_pix;
    logic n_kept;
    logic s2_load;
    logic s1_load;

    dps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dps_decide u_decide (
        .i_cfg  (cfg),
        .i_ctr  (r_ctr),
        .i_up   (r_up),
        .i_dn   (r_dn),
        .i_rt   (r_rt),
        .i_lf   (r_lf),
        .o_pix  (n_pix),
        .o_kept (n_kept)
    );

    assign s2_load    = !r_out_valid || !i_out_stall;
    assign s1_load    = !r_s1_valid || s2_load;
    assign o_in_stall = !s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_ctr <= i_center_pixel[PIXEL_BITS-1:0];
            r_up  <= i_ref_up[PIXEL_BITS-1:0];
            r_dn  <= i_ref_down[PIXEL_BITS-1:0];
            r_rt  <= i_ref_right[PIXEL_BITS-1:0];
            r_lf  <= i_ref_left[PIXEL_BITS-1:0];
        end
        if (s2_load && r_s1_valid) begin
            r_pix  <= n_pix;
            r_kept <= n_kept;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_pixel = FIELD_W'(r_pix);
    assign o_kept_original  = r_kept;

endmodule

// ===== hdl/dps_cfg_regs.sv =====
// configuration registers of the deband pixel select block
// depends on dps_pkg
module dps_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dps_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [dps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output dps_pkg::t_cfg                 o_cfg
);
    import dps_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_PICK_MODE: n_cfg.pick_mode = i_cfg_data[MODE_W-1:0];
                REG_AVG_CMP:   n_cfg.avg_cmp   = i_cfg_data[0];
                REG_THR_AVG:   n_cfg.thr_avg   = i_cfg_data[THR_W-1:0];
                REG_THR_MAX:   n_cfg.thr_max   = i_cfg_data[THR_W-1:0];
                REG_THR_MID:   n_cfg.thr_mid   = i_cfg_data[MID_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pick_mode <= PICK_MODE_RST;
            r_cfg.avg_cmp   <= 1'b1;
            r_cfg.thr_avg   <= '0;
            r_cfg.thr_max   <= '0;
            r_cfg.thr_mid   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== hdl/dps_decide.sv =====
// decision logic: averages the refs and tests the differences against thresholds
// depends on dps_pkg
module dps_decide (
    input  dps_pkg::t_cfg i_cfg,
    input  dps_pkg::t_pix i_ctr,
    input  dps_pkg::t_pix i_up,
    input  dps_pkg::t_pix i_dn,
    input  dps_pkg::t_pix i_rt,
    input  dps_pkg::t_pix i_lf,
    output dps_pkg::t_pix o_pix,
    output logic          o_kept
);
    import dps_pkg::*;

    t_pair    vert;
    t_pair    horz;
    t_pix     avg4;
    t_pix_sum ctr2;
    logic     k_avg4;
    logic     k_each;
    logic     k_max;
    logic     k_mid;

    always_comb begin
        vert = pair_select(i_ctr, i_up, i_dn, i_cfg.avg_cmp, i_cfg.thr_avg);
        horz = pair_select(i_ctr, i_rt, i_lf, i_cfg.avg_cmp, i_cfg.thr_avg);
        avg4 = mean4(i_up, i_rt, i_dn, i_lf);
        ctr2 = {i_ctr, 1'b0};

        k_avg4 = reaches(absdiff(avg4, i_ctr), i_cfg.thr_avg);
        k_each = reaches(absdiff(i_up, i_ctr), i_cfg.thr_avg)
              || reaches(absdiff(i_rt, i_ctr), i_cfg.thr_avg)
              || reaches(absdiff(i_dn, i_ctr), i_cfg.thr_avg)
              || reaches(absdiff(i_lf, i_ctr), i_cfg.thr_avg);
        // max over four diffs reaches threshold iff any one does
        k_max  = reaches(absdiff(i_up, i_ctr), i_cfg.thr_max)
              || reaches(absdiff(i_dn, i_ctr), i_cfg.thr_max)
              || reaches(absdiff(i_rt, i_ctr), i_cfg.thr_max)
              || reaches(absdiff(i_lf, i_ctr), i_cfg.thr_max);
        k_mid  = (CMP_W'(absdiff_sum((PIXEL_BITS+1)'(i_up) + (PIXEL_BITS+1)'(i_dn), ctr2))
                  >= CMP_W'(i_cfg.thr_mid))
              || (CMP_W'(absdiff_sum((PIXEL_BITS+1)'(i_rt) + (PIXEL_BITS+1)'(i_lf), ctr2))
                  >= CMP_W'(i_cfg.thr_mid));

        o_pix  = i_ctr;
        o_kept = 1'b1;
        unique case (t_mode'(i_cfg.pick_mode))
            MODE_VERT: begin
                o_pix  = vert.pix;
                o_kept = vert.kept;
            end
            MODE_HORZ: begin
                o_pix  = horz.pix;
                o_kept = horz.kept;
            end
            MODE_BOTH: begin
                o_pix  = mean2(vert.pix, horz.pix);
                o_kept = vert.kept && horz.kept;
            end
            MODE_DIAG: begin
                o_kept = i_cfg.avg_cmp ? k_avg4 : k_each;
                o_pix  = o_kept ? i_ctr : avg4;
            end
            MODE_FULL: begin
                o_kept = k_avg4 || k_max || k_mid;
                o_pix  = o_kept ? i_ctr : avg4;
            end
            default: begin
                o_pix  = i_ctr;
                o_kept = 1'b1;
            end
        endcase
    end

endmodule
